@@ rtl/core/cpm_pkg.sv @@
package cpm_pkg;

    // Fixed widths of the item fields
    localparam int EXT_POS_W   = 32;
    localparam int OP_CODE_W   = 4;
    localparam int OP_LEN_W    = 28;

    // Default internal position width
    localparam int POS_WIDTH_DEF = 32;

    typedef enum logic [OP_CODE_W-1:0] {
        OP_M  = 4'd0,
        OP_I  = 4'd1,
        OP_D  = 4'd2,
        OP_N  = 4'd3,
        OP_S  = 4'd4,
        OP_H  = 4'd5,
        OP_P  = 4'd6,
        OP_EQ = 4'd7,
        OP_X  = 4'd8
    } cpm_op_t;

endpackage

@@ rtl/core/cpm_if.sv @@
interface cpm_op_if import cpm_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic signed [EXT_POS_W-1:0] start_pos;
    logic signed [EXT_POS_W-1:0] leftmost_pos;
    logic [OP_CODE_W-1:0]        op_code;
    logic [OP_LEN_W-1:0]         op_length;
    logic                        first_op;
    logic                        last_op;

    modport source (
        output valid, func, start_pos, leftmost_pos, op_code, op_length, first_op, last_op,
        input  ready
    );

    modport sink (
        input  valid, func, start_pos, leftmost_pos, op_code, op_length, first_op, last_op,
        output ready
    );
endinterface

interface cpm_res_if import cpm_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [EXT_POS_W-1:0] mapped_pos;
    logic                        not_mappable;

    modport source (
        output valid, mapped_pos, not_mappable,
        input  ready
    );

    modport sink (
        input  valid, mapped_pos, not_mappable,
        output ready
    );
endinterface

@@ rtl/core/cigar_position_mapper_unit.sv @@
// Channel   Role   Item                                         Handshake
// ops       sink   func, start_pos, leftmost_pos, op_code,      valid/ready
//                  op_length, first_op, last_op
// results   source mapped_pos, not_mappable                     valid/ready
// cfg       write  narrow_to_left (cfg_we, cfg_wdata)           write enable only
//
// One op item is taken every cycle unless an item with last_op is stalled; a result is offered once the item
// with last_op has passed the input register and then the mapping step into the result register.
// The rate is set by the update of the running position registers.
// rst_n clears the walk state, the pipeline valid flags and sets narrow_to_left to 1.
// An item with last_op waits in the input register only while the result register is
// still full and not taken; other items never stall.
module cigar_position_mapper_unit import cpm_pkg::*; #(
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    cpm_op_if.sink      ops,
    cpm_res_if.source   results
);

    localparam int EW = ((POS_WIDTH > EXT_POS_W) ? POS_WIDTH : EXT_POS_W) + 2;

    typedef logic signed [EW-1:0]        ew_t;
    typedef logic signed [POS_WIDTH-1:0] pos_t;

    function automatic logic fits_pos(ew_t x);
        return x[EW-1:POS_WIDTH-1] == {(EW-POS_WIDTH+1){x[POS_WIDTH-1]}};
    endfunction

    function automatic logic fits_ext(ew_t x);
        return x[EW-1:EXT_POS_W-1] == {(EW-EXT_POS_W+1){x[EXT_POS_W-1]}};
    endfunction

    // Configuration
    logic ntl_reg;

    // Input register
    logic                s1_valid_reg;
    logic                s1_func_reg;
    logic                s1_first_reg;
    logic                s1_last_reg;
    cpm_op_t             s1_op_reg;
    logic [OP_LEN_W-1:0] s1_len_reg;
    logic                s1_len_bad_reg;
    pos_t                s1_ld_tgt_reg;
    pos_t                s1_ld_run_reg;
    logic                s1_ld_ovf_reg;

    // Walk state
    logic dir_reg;
    pos_t tgt_reg;
    pos_t run_reg;
    pos_t con_reg;
    logic ovf_reg;

    // Result register
    logic                        out_valid_reg;
    logic signed [EXT_POS_W-1:0] out_pos_reg;
    logic                        out_na_reg;

    logic accept;
    logic advance;

    // Record load, computed straight from the ports
    ew_t  ld_s;
    ew_t  ld_l;
    ew_t  ld_mid;
    ew_t  ld_run;
    ew_t  ld_len;
    logic ld_ovf;

    always_comb
    begin
        ld_s   = ew_t'(ops.start_pos);
        ld_l   = ew_t'(ops.leftmost_pos);
        ld_len = ew_t'({1'b0, ops.op_length});
        ld_mid = ops.func ? (ld_s - ld_l) : (ld_s + ld_l);
        ld_run = ops.func ? (ld_mid + ew_t'(1)) : (ld_mid - ew_t'(1));
        ld_ovf = !fits_pos(ld_s) || !fits_pos(ld_l) || !fits_pos(ld_mid) || !fits_pos(ld_run);
    end

    assign advance   = s1_valid_reg && (!s1_last_reg || !out_valid_reg || results.ready);
    assign ops.ready = !s1_valid_reg || advance;
    assign accept    = ops.valid && ops.ready;

    // Mapping step
    logic cur_dir;
    ew_t  tgt_x;
    ew_t  run_x;
    ew_t  con_x;
    ew_t  len_x;
    logic cur_ovf;
    logic walking;
    ew_t  con_plus_len;
    ew_t  run_plus_len;
    ew_t  run_minus_len;
    ew_t  gap_w;
    ew_t  gap_d;
    ew_t  run_in_ins;
    ew_t  run_in_ins_r;
    ew_t  con_r;
    ew_t  run_next;
    ew_t  con_next;
    logic ovf_next;
    logic walk_after;
    logic na_next;

    always_comb
    begin
        cur_dir = s1_first_reg ? s1_func_reg : dir_reg;
        tgt_x   = ew_t'(s1_first_reg ? s1_ld_tgt_reg : tgt_reg);
        run_x   = ew_t'(s1_first_reg ? s1_ld_run_reg : run_reg);
        con_x   = s1_first_reg ? ew_t'(0) : ew_t'(con_reg);
        cur_ovf = s1_first_reg ? s1_ld_ovf_reg : ovf_reg;
        len_x   = ew_t'({1'b0, s1_len_reg});

        walking = cur_dir ? (con_x < run_x) : (con_x < tgt_x);

        con_plus_len  = con_x + len_x;
        run_plus_len  = run_x + len_x;
        run_minus_len = run_x - len_x;
        gap_w         = tgt_x - con_x;
        gap_d         = run_x - con_x;
        run_in_ins    = run_x - gap_w;
        run_in_ins_r  = run_in_ins + ew_t'(1);
        con_r         = con_x + ew_t'(1);

        run_next = run_x;
        con_next = con_x;
        ovf_next = cur_ovf;

        if (!cur_ovf && walking)
        begin
            if (s1_len_bad_reg)
            begin
                ovf_next = 1'b1;
            end
            else if (!cur_dir)
            begin
                case (s1_op_reg) inside
                    OP_M, OP_EQ, OP_X, OP_S:
                    begin
                        con_next = con_plus_len;
                        ovf_next = !fits_pos(con_plus_len);
                    end
                    OP_I:
                    begin
                        // Inside the insertion the position narrows to one of its ends.
                        if (gap_w > len_x)
                        begin
                            run_next = run_minus_len;
                            ovf_next = !fits_pos(run_minus_len);
                        end
                        else if (ntl_reg)
                        begin
                            run_next = run_in_ins;
                            ovf_next = !fits_pos(run_in_ins);
                        end
                        else
                        begin
                            run_next = run_in_ins_r;
                            ovf_next = !fits_pos(run_in_ins) || !fits_pos(run_in_ins_r);
                        end
                        con_next = con_plus_len;
                        ovf_next = ovf_next || !fits_pos(con_plus_len);
                    end
                    OP_D, OP_N:
                    begin
                        run_next = run_plus_len;
                        ovf_next = !fits_pos(run_plus_len);
                    end
                    default:
                    begin
                    end
                endcase
            end
            else
            begin
                case (s1_op_reg) inside
                    OP_M, OP_EQ, OP_X:
                    begin
                        con_next = con_plus_len;
                        ovf_next = !fits_pos(con_plus_len);
                    end
                    OP_I, OP_S:
                    begin
                        run_next = run_plus_len;
                        con_next = con_plus_len;
                        ovf_next = !fits_pos(run_plus_len) || !fits_pos(con_plus_len);
                    end
                    OP_D, OP_N:
                    begin
                        if (gap_d > len_x)
                        begin
                            run_next = run_minus_len;
                            ovf_next = !fits_pos(run_minus_len);
                        end
                        else if (ntl_reg)
                        begin
                            run_next = con_x;
                        end
                        else
                        begin
                            run_next = con_r;
                            ovf_next = !fits_pos(con_r);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        walk_after = cur_dir ? (con_next < run_next) : (con_next < tgt_x);
        na_next    = ovf_next || walk_after || !fits_ext(run_next);
        if (cur_dir)
        begin
            na_next = na_next || run_next[EW-1] || (run_next == ew_t'(0));
        end
        else
        begin
            na_next = na_next || tgt_x[EW-1] || (tgt_x == ew_t'(0));
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ntl_reg       <= 1'b1;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            dir_reg       <= 1'b0;
            tgt_reg       <= '0;
            run_reg       <= '0;
            con_reg       <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ntl_reg <= cfg_wdata;
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance && s1_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                dir_reg <= cur_dir;
                tgt_reg <= pos_t'(tgt_x[POS_WIDTH-1:0]);
                run_reg <= pos_t'(run_next[POS_WIDTH-1:0]);
                con_reg <= pos_t'(con_next[POS_WIDTH-1:0]);
                ovf_reg <= ovf_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg    <= ops.func;
            s1_first_reg   <= ops.first_op;
            s1_last_reg    <= ops.last_op;
            s1_op_reg      <= cpm_op_t'(ops.op_code);
            s1_len_reg     <= ops.op_length;
            s1_len_bad_reg <= !fits_pos(ld_len);
            s1_ld_tgt_reg  <= pos_t'(ld_s[POS_WIDTH-1:0]);
            s1_ld_run_reg  <= pos_t'(ld_run[POS_WIDTH-1:0]);
            s1_ld_ovf_reg  <= ld_ovf;
        end

        if (advance && s1_last_reg)
        begin
            out_pos_reg <= na_next ? '0 : run_next[EXT_POS_W-1:0];
            out_na_reg  <= na_next;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.mapped_pos   = out_pos_reg;
    assign results.not_mappable = out_na_reg;

`ifndef NO_ASSERTIONS
    a_na_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.not_mappable |-> results.mapped_pos == '0)
        else $error("unmappable result carries a nonzero position");

    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_last_reg && out_valid_reg && !results.ready |-> !ops.ready)
        else $error("input taken while a final item is blocked");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_last_reg |=> out_valid_reg)
        else $error("final item produced no result");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg && !(advance && s1_first_reg) |=> ovf_reg)
        else $error("overflow flag cleared within a record");
`endif

endmodule
